### sv/scrgbvs_pkg.sv
// ----------------------------------------------------------------------------
// scrgbvs_pkg: shared types and constants for the scRGB vectorscope mapper
// Holds the pixel and plot point payloads and the configuration register map.
// ----------------------------------------------------------------------------
package scrgbvs_pkg;

    localparam int LIN_W     = 24;   // signed Q7.16 linear channel
    localparam int COORD_W   = 16;   // Q0.16 plot coordinate
    localparam int CFG_W     = 17;   // configuration register width
    localparam int CFG_IDX_W = 2;    // configuration register index width

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_NORM_RECIP = 2'd0,
        CFG_PLOT_SCALE       = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [LIN_W-1:0] red_lin;
        logic signed [LIN_W-1:0] green_lin;
        logic signed [LIN_W-1:0] blue_lin;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] plot_x;
        logic [COORD_W-1:0] plot_y;
        logic               clipped;
    } point_t;

endpackage

### sv/scrgbvs_oetf_lane.sv
// ----------------------------------------------------------------------------
// scrgbvs_oetf_lane: one color channel, normalize and Rec.709 OETF
// Thirteen register stages: magnitude, white normalization, segment select,
// mantissa table interpolation, octave scaling, gain, offset and sign restore.
// ----------------------------------------------------------------------------
module scrgbvs_oetf_lane #(
    parameter int FRAC_BITS          = 16,
    parameter int OETF_TABLE_ENTRIES = 256
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [scrgbvs_pkg::LIN_W-1:0] lin,
    input  logic        [scrgbvs_pkg::CFG_W-1:0] white_norm_recip,
    output logic signed [FRAC_BITS+4:0]          chan
);
    import scrgbvs_pkg::*;

    localparam int PROD_W = LIN_W + CFG_W;
    localparam int A_W    = FRAC_BITS + 8;
    localparam int P_W    = $clog2(A_W);
    localparam int V_W    = FRAC_BITS + 4;
    localparam int S_W    = V_W + 1;
    localparam int NI_W   = $clog2(OETF_TABLE_ENTRIES);
    localparam int MI_W   = $clog2(OETF_TABLE_ENTRIES + 1);
    localparam int POS_W  = 32 + NI_W;
    localparam int PW_W   = 34;
    localparam int PG_W   = PW_W + 31;
    localparam int LN_W   = 34;
    localparam int SH_V   = 30 - FRAC_BITS;
    localparam int LIN_LIMIT = (18 * (1 << FRAC_BITS) + 999) / 1000;

    localparam logic [63:0]     Q30_ONE   = 64'd1 << 30;
    localparam logic [30:0]     GAIN_Q30  = 31'd1180364387;
    localparam logic [LN_W-1:0] OFFS_Q30  = LN_W'(106622563);
    localparam logic [LN_W-1:0] OFFS_ADJ  = OFFS_Q30 - (LN_W'(1) << (29 - FRAC_BITS));
    localparam logic [63:0]     MANT_DIV  = 64'(OETF_TABLE_ENTRIES);

    typedef logic [31:0] mant_rom_t [OETF_TABLE_ENTRIES+1];
    typedef logic [31:0] oct_rom_t [A_W];

    // Integer square root, used only while building the tables.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > n)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2 of a Q.30 value in [1, 2], Q.30 result.
    function automatic logic [63:0] log2_q30(input logic [63:0] m);
        logic [63:0] y;
        logic [63:0] z;
        y = '0;
        z = m;
        if (m >= 2 * Q30_ONE)
        begin
            y = Q30_ONE;
        end
        else
        begin
            for (int i = 1; i <= 30; i++)
            begin
                z = (z * z) >> 30;
                if (z >= 2 * Q30_ONE)
                begin
                    z = z >> 1;
                    y = y | (64'd1 << (30 - i));
                end
            end
        end
        return y;
    endfunction

    // 2^f for a Q.30 fraction, Q.30 result.
    function automatic logic [63:0] exp2_q30(input logic [63:0] f);
        logic [63:0] c;
        logic [63:0] r;
        c = isqrt64(64'd1 << 61);
        r = Q30_ONE;
        for (int i = 1; i <= 30; i++)
        begin
            if (f[30-i])
            begin
                r = (r * c + (64'd1 << 29)) >> 30;
            end
            c = isqrt64(c << 30);
        end
        return r;
    endfunction

    // (1+f)^0.45 on [1, 2], Q.30, forced non-decreasing.
    function automatic mant_rom_t build_mant_rom();
        mant_rom_t   rom;
        logic [63:0] m;
        logic [63:0] l;
        logic [63:0] v;
        for (int k = 0; k <= OETF_TABLE_ENTRIES; k++)
        begin
            m = Q30_ONE + (((64'(k) << 30) + (MANT_DIV >> 1)) / MANT_DIV);
            l = (log2_q30(m) * 9 + 10) / 20;
            v = (l >= Q30_ONE) ? 2 * Q30_ONE : exp2_q30(l);
            if (k > 0 && v < 64'(rom[k-1]))
            begin
                v = 64'(rom[k-1]);
            end
            rom[k] = v[31:0];
        end
        return rom;
    endfunction

    // 2^(0.45*e) per octave, Q.28.
    function automatic oct_rom_t build_oct_rom();
        oct_rom_t    rom;
        longint      e;
        longint      kk;
        longint      q;
        longint      sh;
        logic [63:0] r;
        logic [63:0] base;
        logic [63:0] v;
        for (int p = 0; p < A_W; p++)
        begin
            e    = longint'(p) - longint'(FRAC_BITS);
            kk   = 9 * e + 640;
            q    = kk / 20 - 32;
            r    = 64'(kk % 20);
            base = exp2_q30((r * Q30_ONE + 10) / 20);
            sh   = q - 2;
            if (sh >= 0)
            begin
                v = base << sh;
            end
            else
            begin
                v = (base + (64'd1 << (-sh - 1))) >> (-sh);
            end
            rom[p] = v[31:0];
        end
        return rom;
    endfunction

    localparam mant_rom_t MANT_ROM = build_mant_rom();
    localparam oct_rom_t  OCT_ROM  = build_oct_rom();

    // Pipeline registers
    logic [LIN_W-1:0]  mag_reg;
    logic [A_W-1:0]    a_reg;
    logic [A_W-1:0]    a3_reg;
    logic [P_W-1:0]    p_reg;
    logic [31:0]       f32_reg;
    logic [NI_W-1:0]   idx_reg;
    logic [15:0]       fr5_reg;
    logic [31:0]       m0_reg;
    logic [31:0]       m1_reg;
    logic [15:0]       fr6_reg;
    logic [47:0]       prodi_reg;
    logic [31:0]       m0b_reg;
    logic [31:0]       m_reg;
    logic [63:0]       mo_reg;
    logic [PG_W-1:0]   pg_reg;
    logic [LN_W-1:0]   ln_reg;
    logic [V_W-1:0]    v_reg;
    logic signed [S_W-1:0] chan_reg;
    logic [11:0]       neg_reg;
    logic [8:0]        linseg_reg;
    logic [V_W-1:0]    vlin_reg [9];
    logic [31:0]       oct_reg [5];

    // Next values
    logic [LIN_W-1:0]  lin_u;
    logic [LIN_W-1:0]  mag_next;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] sum_a;
    logic [A_W-1:0]    a_next;
    logic [P_W-1:0]    p_next;
    logic              linseg_next;
    logic [A_W+3:0]    a9;
    logic [V_W-1:0]    vlin_next;
    logic [A_W+31:0]   shifted;
    logic [31:0]       f32_next;
    logic [31:0]       oct_next;
    logic [POS_W-1:0]  pos;
    logic [NI_W-1:0]   idx_next;
    logic [15:0]       fr_next;
    logic [MI_W-1:0]   idx_ext;
    logic [31:0]       m0_next;
    logic [31:0]       m1_next;
    logic [31:0]       diff;
    logic [47:0]       prodi_next;
    logic [47:0]       prodi_rnd;
    logic [31:0]       m_next;
    logic [63:0]       mo_next;
    logic [63:0]       mo_rnd;
    logic [PW_W-1:0]   pw;
    logic [PG_W-1:0]   pg_next;
    logic [PG_W-1:0]   pg_rnd;
    logic [LN_W-1:0]   ln_next;
    logic [LN_W-1:0]   ln_sub;
    logic [V_W-1:0]    vpow;
    logic [V_W-1:0]    v_next;
    logic signed [S_W-1:0] v_signed;
    logic signed [S_W-1:0] chan_next;

    // Magnitude and sign
    assign lin_u    = $unsigned(lin);
    assign mag_next = lin_u[LIN_W-1] ? (~lin_u + 1'b1) : lin_u;

    // White normalization, half rounded up
    assign prod_a = PROD_W'(mag_reg) * PROD_W'(white_norm_recip);
    assign sum_a  = prod_a + (PROD_W'(1) << (31 - FRAC_BITS));
    assign a_next = sum_a[32-FRAC_BITS +: A_W];

    // Segment select, leading one, linear segment value
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < A_W; i++)
        begin
            if (a_reg[i])
            begin
                p_next = P_W'(i);
            end
        end
    end

    assign linseg_next = (a_reg < A_W'(LIN_LIMIT));
    assign a9          = (A_W+4)'({a_reg, 3'b000}) + (A_W+4)'(a_reg) + (A_W+4)'(1);
    assign vlin_next   = a9[1 +: V_W];

    // Left-align the bits below the leading one, fetch octave scale
    assign shifted  = {a3_reg, 32'b0} >> p_reg;
    assign f32_next = shifted[31:0];
    assign oct_next = OCT_ROM[p_reg];

    // Table position and interpolation fraction
    assign pos      = POS_W'(f32_reg) * POS_W'(OETF_TABLE_ENTRIES);
    assign idx_next = pos[32 +: NI_W];
    assign fr_next  = pos[16 +: 16];

    // Mantissa table neighbors
    assign idx_ext = MI_W'(idx_reg);
    assign m0_next = MANT_ROM[idx_ext];
    assign m1_next = MANT_ROM[idx_ext + MI_W'(1)];

    // Interpolate
    assign diff       = m1_reg - m0_reg;
    assign prodi_next = 48'(diff) * 48'(fr6_reg);
    assign prodi_rnd  = prodi_reg + 48'd32768;
    assign m_next     = m0b_reg + prodi_rnd[47:16];

    // Octave scale, gain
    assign mo_next = 64'(m_reg) * 64'(oct_reg[4]);
    assign mo_rnd  = mo_reg + (64'd1 << 27);
    assign pw      = mo_rnd[28 +: PW_W];
    assign pg_next = PG_W'(pw) * PG_W'(GAIN_Q30);
    assign pg_rnd  = pg_reg + (PG_W'(1) << 29);
    assign ln_next = pg_rnd[30 +: LN_W];

    // Offset, floor at zero, round to output precision
    assign ln_sub = ln_reg - OFFS_ADJ;
    assign vpow   = (ln_reg < OFFS_Q30) ? '0 : ln_sub[SH_V +: V_W];
    assign v_next = linseg_reg[8] ? vlin_reg[8] : vpow;

    // Restore sign
    assign v_signed  = $signed({1'b0, v_reg});
    assign chan_next = neg_reg[11] ? -v_signed : v_signed;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= mag_next;
            a_reg      <= a_next;
            a3_reg     <= a_reg;
            p_reg      <= p_next;
            f32_reg    <= f32_next;
            idx_reg    <= idx_next;
            fr5_reg    <= fr_next;
            m0_reg     <= m0_next;
            m1_reg     <= m1_next;
            fr6_reg    <= fr5_reg;
            prodi_reg  <= prodi_next;
            m0b_reg    <= m0_reg;
            m_reg      <= m_next;
            mo_reg     <= mo_next;
            pg_reg     <= pg_next;
            ln_reg     <= ln_next;
            v_reg      <= v_next;
            chan_reg   <= chan_next;
            neg_reg    <= {neg_reg[10:0], lin_u[LIN_W-1]};
            linseg_reg <= {linseg_reg[7:0], linseg_next};
            vlin_reg[0] <= vlin_next;
            for (int i = 1; i < 9; i++)
            begin
                vlin_reg[i] <= vlin_reg[i-1];
            end
            oct_reg[0] <= oct_next;
            for (int i = 1; i < 5; i++)
            begin
                oct_reg[i] <= oct_reg[i-1];
            end
        end
    end

    assign chan = chan_reg;

endmodule

### sv/scrgbvs_chroma.sv
// ----------------------------------------------------------------------------
// scrgbvs_chroma: Rec.709 Cb/Cr and vectorscope plot position
// Four register stages: color matrix, scale, rounding, centering with clamp.
// ----------------------------------------------------------------------------
module scrgbvs_chroma #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [FRAC_BITS+4:0]          red,
    input  logic signed [FRAC_BITS+4:0]          green,
    input  logic signed [FRAC_BITS+4:0]          blue,
    input  logic        [scrgbvs_pkg::CFG_W-1:0] plot_scale,
    output scrgbvs_pkg::point_t                  point
);
    import scrgbvs_pkg::*;

    localparam int CB_W = FRAC_BITS + 21;
    localparam int XS_W = CB_W + CFG_W + 1;
    localparam int RS   = 16 + FRAC_BITS;
    localparam int Q_W  = XS_W - RS;
    localparam int C_W  = Q_W + 2;

    localparam int CB_R = -7509;
    localparam int CB_G = -25259;
    localparam int CB_B = 32768;
    localparam int CR_R = 32768;
    localparam int CR_G = -29763;
    localparam int CR_B = -3005;

    logic signed [CB_W-1:0] cb_reg;
    logic signed [CB_W-1:0] cr_reg;
    logic signed [XS_W-1:0] xcb_reg;
    logic signed [XS_W-1:0] xcr_reg;
    logic signed [Q_W-1:0]  qcb_reg;
    logic signed [Q_W-1:0]  qcr_reg;
    point_t                 point_reg;

    logic signed [CB_W-1:0] cb_next;
    logic signed [CB_W-1:0] cr_next;
    logic signed [XS_W-1:0] scale_s;
    logic signed [XS_W-1:0] xcb_next;
    logic signed [XS_W-1:0] xcr_next;
    logic signed [XS_W-1:0] half;
    logic signed [XS_W-1:0] sum_cb;
    logic signed [XS_W-1:0] sum_cr;
    logic signed [Q_W-1:0]  qcb_next;
    logic signed [Q_W-1:0]  qcr_next;
    logic signed [C_W-1:0]  px;
    logic signed [C_W-1:0]  py;
    logic                   clip_x;
    logic                   clip_y;
    point_t                 point_next;

    assign cb_next = CB_W'(red) * CB_W'(CB_R) + CB_W'(green) * CB_W'(CB_G)
                   + CB_W'(blue) * CB_W'(CB_B);
    assign cr_next = CB_W'(red) * CB_W'(CR_R) + CB_W'(green) * CB_W'(CR_G)
                   + CB_W'(blue) * CB_W'(CR_B);

    assign scale_s  = $signed(XS_W'(plot_scale));
    assign xcb_next = XS_W'(cb_reg) * scale_s;
    assign xcr_next = XS_W'(cr_reg) * scale_s;

    // Round half away from zero: negative values take half minus one,
    // then an arithmetic shift.
    assign half     = $signed(XS_W'(1) << (RS - 1));
    assign sum_cb   = xcb_reg + (xcb_reg[XS_W-1] ? half - XS_W'(1) : half);
    assign sum_cr   = xcr_reg + (xcr_reg[XS_W-1] ? half - XS_W'(1) : half);
    assign qcb_next = $signed(sum_cb[RS +: Q_W]);
    assign qcr_next = $signed(sum_cr[RS +: Q_W]);

    // Center on the plot and saturate to the edges
    assign px = C_W'(32768) + C_W'(qcb_reg);
    assign py = C_W'(32768) - C_W'(qcr_reg);

    always_comb
    begin
        point_next = '0;
        clip_x     = 1'b0;
        clip_y     = 1'b0;
        if (px < 0)
        begin
            point_next.plot_x = '0;
            clip_x            = 1'b1;
        end
        else if (px > C_W'(65535))
        begin
            point_next.plot_x = '1;
            clip_x            = 1'b1;
        end
        else
        begin
            point_next.plot_x = px[COORD_W-1:0];
        end
        if (py < 0)
        begin
            point_next.plot_y = '0;
            clip_y            = 1'b1;
        end
        else if (py > C_W'(65535))
        begin
            point_next.plot_y = '1;
            clip_y            = 1'b1;
        end
        else
        begin
            point_next.plot_y = py[COORD_W-1:0];
        end
        point_next.clipped = clip_x | clip_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg    <= cb_next;
            cr_reg    <= cr_next;
            xcb_reg   <= xcb_next;
            xcr_reg   <= xcr_next;
            qcb_reg   <= qcb_next;
            qcr_reg   <= qcr_next;
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

### sv/scrgb_to_vectorscope_point.sv
// ----------------------------------------------------------------------------
// scrgb_to_vectorscope_point: linear scRGB pixel to vectorscope position
// Normalizes each channel to SDR white, applies the Rec.709 OETF and maps
// Rec.709 Cb/Cr to a saturated Q0.16 plot position with a clip flag.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel requests enter on in_valid/in_ready with in_pixel (three signed
//   Q7.16 channels). Plot points leave on out_valid/out_ready with out_point.
//   Two registers are written over cfg_valid/cfg_ready with cfg_index and
//   cfg_data: index 0 is white_norm_recip, index 1 is plot_scale (Q1.16).
//   Writes to any other index are dropped. The config port always accepts;
//   write it only while no pixel is in flight.
//
//   Pipeline: 13 register stages in each channel lane, then 4 in the
//   chroma stage, between an accepted pixel and its point on the output.
//   Throughput: one pixel per clock unless the output stalls. Each lane stage
//   holds at most one multiply (up to 34x31) or a table read; the widest
//   multiplies (table interpolation, octave scale, gain) set the clock.
//
//   When the receiver stalls with a point waiting, the whole pipeline holds
//   and in_ready drops in the same cycle; no request is lost or repeated.
//   Reset clears all valid bits and returns both registers to 1.0 (65536).
// ----------------------------------------------------------------------------
module scrgb_to_vectorscope_point #(
    parameter int FRAC_BITS          = 16,
    parameter int OETF_TABLE_ENTRIES = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  scrgbvs_pkg::pixel_t                      in_pixel,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output scrgbvs_pkg::point_t                      out_point,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [scrgbvs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scrgbvs_pkg::CFG_W-1:0]            cfg_data
);
    import scrgbvs_pkg::*;

    localparam int LANE_LAT   = 13;
    localparam int CHROMA_LAT = 4;
    localparam int LAT        = LANE_LAT + CHROMA_LAT;
    localparam int CH_W       = FRAC_BITS + 5;

    localparam logic [CFG_W-1:0] WHITE_NORM_RECIP_RST = CFG_W'(65536);
    localparam logic [CFG_W-1:0] PLOT_SCALE_RST       = CFG_W'(65536);

    logic [CFG_W-1:0]       white_norm_recip_reg;
    logic [CFG_W-1:0]       plot_scale_reg;
    logic [LAT-1:0]         valid_reg;
    logic [LAT-1:0]         valid_next;
    logic                   en;
    logic signed [CH_W-1:0] red_ch;
    logic signed [CH_W-1:0] green_ch;
    logic signed [CH_W-1:0] blue_ch;

    // Advance every stage unless a finished point waits at the output.
    assign en        = ~valid_reg[LAT-1] | out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[LAT-1];
    assign cfg_ready = 1'b1;

    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    // Valid bits travel alongside the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_norm_recip_reg <= WHITE_NORM_RECIP_RST;
            plot_scale_reg       <= PLOT_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WHITE_NORM_RECIP: white_norm_recip_reg <= cfg_data;
                CFG_PLOT_SCALE:       plot_scale_reg       <= cfg_data;
                default:              ;
            endcase
        end
    end

    // One lane per color channel
    scrgbvs_oetf_lane #(
        .FRAC_BITS          (FRAC_BITS),
        .OETF_TABLE_ENTRIES (OETF_TABLE_ENTRIES)
    ) u_lane_red (
        .clk              (clk),
        .en               (en),
        .lin              (in_pixel.red_lin),
        .white_norm_recip (white_norm_recip_reg),
        .chan             (red_ch)
    );

    scrgbvs_oetf_lane #(
        .FRAC_BITS          (FRAC_BITS),
        .OETF_TABLE_ENTRIES (OETF_TABLE_ENTRIES)
    ) u_lane_green (
        .clk              (clk),
        .en               (en),
        .lin              (in_pixel.green_lin),
        .white_norm_recip (white_norm_recip_reg),
        .chan             (green_ch)
    );

    scrgbvs_oetf_lane #(
        .FRAC_BITS          (FRAC_BITS),
        .OETF_TABLE_ENTRIES (OETF_TABLE_ENTRIES)
    ) u_lane_blue (
        .clk              (clk),
        .en               (en),
        .lin              (in_pixel.blue_lin),
        .white_norm_recip (white_norm_recip_reg),
        .chan             (blue_ch)
    );

    // Color matrix, scale and plot mapping; its last stage is the output
    // register.
    scrgbvs_chroma #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chroma (
        .clk        (clk),
        .en         (en),
        .red        (red_ch),
        .green      (green_ch),
        .blue       (blue_ch),
        .plot_scale (plot_scale_reg),
        .point      (out_point)
    );

endmodule
